// File: design/erbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erbe_pkg
// Shared types, widths and the binomial table builder of the rank extractor.
// ----------------------------------------------------------------------------
package erbe_pkg;

	localparam int MAX_BLOCK = 32;
	localparam int ROW       = MAX_BLOCK + 1;
	localparam int TAB_DEPTH = ROW * ROW;
	localparam int ADDR_W    = $clog2(TAB_DEPTH);

	localparam int SYM_W  = 8;
	localparam int LEN_W  = 6;
	localparam int VAL_W  = 30;
	localparam int SPAN_W = VAL_W + 1;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 8;

	localparam logic [SYM_W-1:0] EVENT_SYMBOL_RST = 8'd49;
	localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = 6'd8;
	localparam logic [CNT_W-1:0] LAST_STEP        = 5'd30;

	typedef enum logic [IDX_W-1:0] {
		REG_EVENT_SYMBOL = 2'd0,
		REG_BLOCK_LENGTH = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANK_RD,
		ST_RANK_ADD,
		ST_TOTAL_RD,
		ST_TOTAL_CHK,
		ST_EXTRACT,
		ST_EMIT
	} erbe_state_t;

	typedef struct packed {
		logic             en;
		logic [LEN_W-1:0] n;
		logic [LEN_W-1:0] k;
	} rom_req_t;

	typedef logic [TAB_DEPTH-1:0][VAL_W-1:0] binom_tab_t;

	// pascal triangle, row n at n*ROW, zero where k > n
	function automatic binom_tab_t erbe_build_binom();
		binom_tab_t tab;
		tab = '0;
		for (int n = 0; n < ROW; n++) begin
			for (int k = 0; k <= n; k++) begin
				if (k == 0 || k == n) begin
					tab[n*ROW + k] = VAL_W'(1);
				end else begin
					tab[n*ROW + k] = tab[(n-1)*ROW + k - 1] + tab[(n-1)*ROW + k];
				end
			end
		end
		return tab;
	endfunction

endpackage

// File: design/erbe_binom_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erbe_binom_rom
// Binomial coefficient table C(n, k) with a registered read port.
// ----------------------------------------------------------------------------
module erbe_binom_rom (
	input  logic                        clk,
	input  erbe_pkg::rom_req_t          req,
	output logic [erbe_pkg::VAL_W-1:0]  data
);
	import erbe_pkg::*;

	localparam binom_tab_t BINOM = erbe_build_binom();

	logic              in_range;
	logic [ADDR_W-1:0] addr;
	logic [VAL_W-1:0]  data_q;

	assign in_range = (req.n <= LEN_W'(MAX_BLOCK)) && (req.k <= LEN_W'(MAX_BLOCK));
	assign addr     = ADDR_W'(req.n) * ADDR_W'(ROW) + ADDR_W'(req.k);

	always_ff @(posedge clk) begin
		if (req.en) begin
			data_q <= in_range ? BINOM[addr] : '0;
		end
	end

	assign data = data_q;

endmodule

// File: design/enumerative_rank_bit_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enumerative_rank_bit_extractor
// Ranks the event pattern of each symbol block and extracts unbiased bits.
// ----------------------------------------------------------------------------
//  channel  signals                                        dir  width
//  in       in_valid in_ready symbol end_of_stream         in   8 + 1
//  out      out_valid out_ready extracted_bits bit_count   out  30 + 5 + 6
//           event_total
//  cfg      cfg_valid cfg_ready cfg_index cfg_data         in   2 + 8
//
//  a symbol that does not close its block steps through accept, table
//  read and rank add; a closing symbol then adds the total lookup (read,
//  check), a scan of one bit position of the total per step, up to 30
//  positions and skipped for a total of one, and the output register load.
//  the single table port and the one-step interval scan shape this order.
//  reset clears counters, the rank and the output valid flag and loads the
//  register defaults. a stalled output register holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
module enumerative_rank_bit_extractor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [erbe_pkg::SYM_W-1:0]  symbol,
	input  logic                        end_of_stream,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [erbe_pkg::VAL_W-1:0]  extracted_bits,
	output logic [erbe_pkg::CNT_W-1:0]  bit_count,
	output logic [erbe_pkg::LEN_W-1:0]  event_total,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [erbe_pkg::IDX_W-1:0]  cfg_index,
	input  logic [erbe_pkg::CFG_W-1:0]  cfg_data
);
	import erbe_pkg::*;

	erbe_state_t state_q, state_nxt;

	logic [SYM_W-1:0]  event_symbol_q;
	logic [LEN_W-1:0]  block_length_q;
	logic [LEN_W-1:0]  len_eff;

	logic [LEN_W-1:0]  pos_q;
	logic [LEN_W-1:0]  tally_q;
	logic [VAL_W-1:0]  rank_q;
	logic              hit_q;
	logic              eos_q;

	logic [SPAN_W-1:0] span_q;
	logic [SPAN_W-1:0] partial_q;
	logic [CNT_W-1:0]  step_q;
	logic [CNT_W-1:0]  count_q;
	logic [VAL_W-1:0]  bits_q;

	logic              out_valid_q;
	logic [VAL_W-1:0]  extracted_bits_q;
	logic [CNT_W-1:0]  bit_count_q;
	logic [LEN_W-1:0]  event_total_q;

	rom_req_t          rom_req;
	logic [VAL_W-1:0]  rom_data;

	logic              in_fire;
	logic              out_fire;
	logic [LEN_W-1:0]  pos_nxt;
	logic              close_blk;
	logic [SPAN_W-1:0] partial_nxt;
	logic              found;
	logic [SPAN_W-1:0] low_mask;
	logic              emit_load;

	erbe_binom_rom u_rom (
		.clk  (clk),
		.req  (rom_req),
		.data (rom_data)
	);

	always_comb begin
		if (block_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (block_length_q > LEN_W'(MAX_BLOCK)) begin
			len_eff = LEN_W'(MAX_BLOCK);
		end else begin
			len_eff = block_length_q;
		end
	end

	assign in_fire     = in_valid && in_ready;
	assign out_fire    = out_valid_q && out_ready;
	assign pos_nxt     = pos_q + LEN_W'(1);
	assign close_blk   = (pos_nxt >= len_eff) || eos_q;
	// running sum of the interval sizes reached so far
	assign partial_nxt = partial_q | ({1'b0, rom_data} & span_q);
	assign found       = partial_nxt > {1'b0, rank_q};
	assign low_mask    = span_q - SPAN_W'(1);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_nxt = ST_RANK_RD;
			end
			ST_RANK_RD:  state_nxt = ST_RANK_ADD;
			ST_RANK_ADD: state_nxt = close_blk ? ST_TOTAL_RD : ST_IDLE;
			ST_TOTAL_RD: state_nxt = ST_TOTAL_CHK;
			ST_TOTAL_CHK: begin
				state_nxt = (rom_data == VAL_W'(1)) ? ST_EMIT : ST_EXTRACT;
			end
			ST_EXTRACT: begin
				if (found || step_q == LAST_STEP) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_load) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready    = 1'b0;
		emit_load   = 1'b0;
		rom_req.en  = 1'b0;
		rom_req.n   = pos_q;
		rom_req.k   = tally_q;
		case (state_q)
			ST_IDLE:    in_ready = 1'b1;
			ST_RANK_RD: rom_req.en = 1'b1;
			ST_TOTAL_RD: begin
				rom_req.en = 1'b1;
				rom_req.n  = len_eff;
			end
			ST_EMIT:    emit_load = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_symbol_q <= EVENT_SYMBOL_RST;
			block_length_q <= BLOCK_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EVENT_SYMBOL: event_symbol_q <= cfg_data;
				REG_BLOCK_LENGTH: block_length_q <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// block counters and rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tally_q <= '0;
			rank_q  <= '0;
			hit_q   <= 1'b0;
			eos_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						hit_q <= (symbol == event_symbol_q);
						eos_q <= end_of_stream;
						if (symbol == event_symbol_q) tally_q <= tally_q + LEN_W'(1);
					end
				end
				ST_RANK_ADD: begin
					if (hit_q) rank_q <= rank_q + rom_data;
					pos_q <= pos_nxt;
				end
				ST_EMIT: begin
					if (emit_load) begin
						pos_q   <= '0;
						tally_q <= '0;
						rank_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// interval scan, one bit position of the total per step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_TOTAL_CHK: begin
				span_q    <= SPAN_W'(2);
				partial_q <= '0;
				step_q    <= CNT_W'(1);
				count_q   <= '0;
				bits_q    <= '0;
			end
			ST_EXTRACT: begin
				partial_q <= partial_nxt;
				span_q    <= span_q << 1;
				step_q    <= step_q + CNT_W'(1);
				if (found) begin
					count_q <= step_q;
					bits_q  <= rank_q & low_mask[VAL_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			extracted_bits_q <= bits_q;
			bit_count_q      <= count_q;
			event_total_q    <= tally_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign extracted_bits = extracted_bits_q;
	assign bit_count      = bit_count_q;
	assign event_total    = event_total_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bit_count <= LAST_STEP)
		else $error("bit_count beyond 30");

	a_bits_fit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (extracted_bits >> bit_count) == '0)
		else $error("extracted bits above bit_count");

	a_tally_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> tally_q <= pos_q)
		else $error("event tally exceeds block position");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while sequencer busy");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the enumerative rank bit extractor against a rank and interval
// predictor. Symbols and register writes go in over valid/ready channels.
// Every closed block is compared field by field with the predicted beat.
// A directed part covers a total of one, the remainder interval, a zero total,
// a block length of zero, a block length that is too large, a block length
// lowered mid-block, a partial block and unknown register indexes. Random
// phases then vary the registers, the event density and the idling on both
// sides. One phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;

	import erbe_pkg::*;

	localparam int  RANDOM_ITEMS = 1750;
	localparam int  QUIET_CYCLES = 48;
	localparam int  HOLD_CYCLES  = 320;
	localparam int  DRAIN_LIMIT  = 20000;
	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  PRINT_CAP    = 100;

	// indexes with no register behind them
	localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [VAL_W-1:0] bits;
		logic [CNT_W-1:0] count;
		logic [LEN_W-1:0] events;
	} extract_t;

	class rank_scoreboard;
		logic [SYM_W-1:0] event_sym;
		logic [LEN_W-1:0] blk_len;
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] tally;
		logic [VAL_W-1:0] rank;
		logic [VAL_W-1:0] pascal [0:MAX_BLOCK][0:MAX_BLOCK];
		extract_t         expected_q [$];
		int               errors;
		int               symbols_in;
		int               blocks_out;
		int               empty_blocks;
		int               widest;
		int               reg_writes;

		function new();
			for (int n = 0; n <= MAX_BLOCK; n++) begin
				for (int k = 0; k <= MAX_BLOCK; k++) begin
					if (k > n) begin
						pascal[n][k] = '0;
					end else if (k == 0 || k == n) begin
						pascal[n][k] = VAL_W'(1);
					end else begin
						pascal[n][k] = pascal[n-1][k-1] + pascal[n-1][k];
					end
				end
			end
			event_sym    = EVENT_SYMBOL_RST;
			blk_len      = BLOCK_LENGTH_RST;
			pos          = '0;
			tally        = '0;
			rank         = '0;
			errors       = 0;
			symbols_in   = 0;
			blocks_out   = 0;
			empty_blocks = 0;
			widest       = 0;
			reg_writes   = 0;
		endfunction

		function logic [VAL_W-1:0] choose(int n, int k);
			if (n > MAX_BLOCK || k > MAX_BLOCK || k > n) begin
				return '0;
			end
			return pascal[n][k];
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_EVENT_SYMBOL: event_sym = data;
				REG_BLOCK_LENGTH: blk_len = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// rank accumulation and interval split of one symbol beat
		function void note_input(logic [SYM_W-1:0] sym, logic eos);
			int               len;
			int               i;
			int               count;
			logic [VAL_W-1:0] total;
			longint           limit;
			longint           span;
			longint           mask;
			extract_t         exp_beat;
			symbols_in++;
			if (blk_len == 0) begin
				len = 1;
			end else if (blk_len > MAX_BLOCK) begin
				len = MAX_BLOCK;
			end else begin
				len = blk_len;
			end
			if (sym == event_sym) begin
				tally = tally + 1'b1;
				rank  = rank + choose(pos, tally);
			end
			pos = pos + 1'b1;
			if (pos < len && !eos) begin
				return;
			end
			total = choose(len, tally);
			count = 0;
			if (total != 1) begin
				limit = -1;
				span  = 1;
				for (i = 1; i <= 30; i++) begin
					span = span << 1;
					if (i < VAL_W && total[i]) begin
						limit += span;
					end
					if (count == 0 && limit >= longint'(rank)) begin
						count = i;
					end
				end
			end
			mask            = (longint'(1) << count) - 1;
			exp_beat.bits   = (count == 0) ? '0 : (rank & mask[VAL_W-1:0]);
			exp_beat.count  = CNT_W'(count);
			exp_beat.events = tally;
			expected_q.push_back(exp_beat);
			pos   = '0;
			tally = '0;
			rank  = '0;
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_CAP) begin
				$display("[%0t] mismatch: %s", $realtime, what);
			end
		endtask

		task check_result(logic [VAL_W-1:0] bits, logic [CNT_W-1:0] count,
				logic [LEN_W-1:0] events);
			extract_t exp_beat;
			if (expected_q.size() == 0) begin
				report($sformatf("beat with no block closed: bits %0h count %0d events %0d",
					bits, count, events));
				return;
			end
			exp_beat = expected_q.pop_front();
			blocks_out++;
			if (exp_beat.count == 0) begin
				empty_blocks++;
			end
			if (exp_beat.count > widest) begin
				widest = int'(exp_beat.count);
			end
			if (bits !== exp_beat.bits) begin
				report($sformatf("block %0d extracted_bits %0h, predicted %0h",
					blocks_out, bits, exp_beat.bits));
			end
			if (count !== exp_beat.count) begin
				report($sformatf("block %0d bit_count %0d, predicted %0d",
					blocks_out, count, exp_beat.count));
			end
			if (events !== exp_beat.events) begin
				report($sformatf("block %0d event_total %0d, predicted %0d",
					blocks_out, events, exp_beat.events));
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [SYM_W-1:0]   symbol = '0;
	logic               end_of_stream = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VAL_W-1:0]   extracted_bits;
	logic [CNT_W-1:0]   bit_count;
	logic [LEN_W-1:0]   event_total;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	rank_scoreboard sb;
	bit             send_idle = 1'b0;
	bit             recv_idle = 1'b0;
	bit             hold_req = 1'b0;
	int             cycle_count = 0;

	enumerative_rank_bit_extractor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.symbol         (symbol),
		.end_of_stream  (end_of_stream),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.extracted_bits (extracted_bits),
		.bit_count      (bit_count),
		.event_total    (event_total),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(12, 50);
	endfunction

	task automatic send(logic [SYM_W-1:0] sym, logic eos);
		int gap;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		symbol        <= sym;
		end_of_stream <= eos;
		do @(posedge clk); while (!in_ready);
		sb.note_input(sym, eos);
	endtask

	// cfg_valid stays up across back-to-back writes
	task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic cfg_done();
		cfg_valid <= 1'b0;
	endtask

	// let every closed block drain, then give a silent block time to settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// output side: random stalls plus one long hold-off on request
	initial begin
		int idle_left;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(extracted_bits, bit_count, event_total);
				if (recv_idle) begin
					idle_left = pick_gap();
				end
			end
			if (hold_req) begin
				idle_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (idle_left > 0) begin
				out_ready <= 1'b0;
				idle_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int               sent;
		int               phase;
		int               n_items;
		int               hit_pct;
		int               r;
		int               w;
		logic [SYM_W-1:0] phase_sym;
		logic [CFG_W-1:0] len_val;
		logic [SYM_W-1:0] sym;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all events in a full block: total of one
		repeat (8) send(EVENT_SYMBOL_RST, 1'b0);
		// partial block closed by end of stream
		send(8'd0, 1'b0);
		send(8'd255, 1'b0);
		send(EVENT_SYMBOL_RST, 1'b1);

		// rank lands in the size-one remainder of an odd total
		quiesce();
		cfg_write(REG_EVENT_SYMBOL, 8'd255);
		cfg_write(REG_BLOCK_LENGTH, 8'd3);
		cfg_done();
		send(8'd0, 1'b0);
		send(8'd0, 1'b0);
		send(8'd255, 1'b0);

		// long block cut short by a lower length, more events than length
		quiesce();
		cfg_write(REG_BLOCK_LENGTH, 8'd32);
		cfg_done();
		repeat (5) send(8'd255, 1'b0);
		quiesce();
		cfg_write(REG_BLOCK_LENGTH, 8'd3);
		cfg_done();
		send(8'd255, 1'b0);

		// length zero behaves as one
		quiesce();
		cfg_write(REG_BLOCK_LENGTH, 8'd0);
		cfg_done();
		send(8'd255, 1'b0);
		send(8'd0, 1'b0);

		// oversized length clamps, unknown indexes change nothing
		quiesce();
		cfg_write(REG_EVENT_SYMBOL, 8'd0);
		cfg_write(REG_BLOCK_LENGTH, 8'd255);
		cfg_write(REG_SPARE_A, 8'd5);
		cfg_write(REG_SPARE_B, 8'd2);
		cfg_done();
		repeat (3) send(8'd0, 1'b0);
		send(8'd0, 1'b1);

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			quiesce();
			r = $urandom_range(0, 99);
			if (phase == 1) begin
				len_val = 8'd1;
			end else if (r < 45) begin
				len_val = CFG_W'($urandom_range(1, 8));
			end else if (r < 75) begin
				len_val = CFG_W'($urandom_range(9, 16));
			end else if (r < 88) begin
				len_val = CFG_W'($urandom_range(17, 32));
			end else if (r < 94) begin
				len_val = 8'd0;
			end else begin
				len_val = CFG_W'($urandom_range(33, 255));
			end
			r = $urandom_range(0, 9);
			if (r == 0) begin
				phase_sym = 8'd0;
			end else if (r == 1) begin
				phase_sym = 8'd255;
			end else begin
				phase_sym = SYM_W'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 3) != 0) begin
				cfg_write(REG_EVENT_SYMBOL, phase_sym);
			end else begin
				phase_sym = sb.event_sym;
			end
			cfg_write(REG_BLOCK_LENGTH, len_val);
			if ($urandom_range(0, 9) == 0) begin
				cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_W'($urandom_range(0, 255)));
			end
			cfg_done();

			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			hit_pct   = $urandom_range(5, 95);
			n_items   = $urandom_range(30, 120);
			if (phase == 1) begin
				send_idle = 1'b0;
				hold_req  = 1'b1;
			end
			repeat (n_items) begin
				if ($urandom_range(0, 99) < hit_pct) begin
					sym = phase_sym;
				end else begin
					sym = SYM_W'($urandom_range(0, 255));
				end
				send(sym, $urandom_range(0, 39) == 0);
				sent++;
			end
			phase++;
		end

		in_valid <= 1'b0;
		for (w = 0; w < DRAIN_LIMIT && sb.pending() != 0; w++) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d predicted blocks never came out", sb.pending()));
		end
		repeat (QUIET_CYCLES) @(posedge clk);

		$display("ran %0d symbols in %0d random phases, %0d register writes",
			sb.symbols_in, phase, sb.reg_writes);
		$display("%0d blocks closed, %0d gave no bits, widest gave %0d bits, %0d mismatches",
			sb.blocks_out, sb.empty_blocks, sb.widest, sb.errors);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
